@@ rtl/cfd_pkg.sv @@
// shared types, codes and the crc-16/arc byte update for the frame deframer
// no dependencies; the other files that use this package refer to it by scoped names

package cfd_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0]  START_BYTE1 = 8'h7E;
	localparam logic [7:0]  START_BYTE2 = 8'hE7;
	localparam logic [7:0]  TAIL_BYTE1  = 8'hE7;
	localparam logic [7:0]  TAIL_BYTE2  = 8'h7E;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [15:0] CRC_INIT    = 16'h0000;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_START = 2'd1,
		ST_TAIL  = 2'd2,
		ST_CRC   = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		KIND_DATA   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		CMD_CRC_CLR   = 3'd0,
		CMD_DATA      = 3'd1,
		CMD_CRC_HI    = 3'd2,
		CMD_CRC_LO    = 3'd3,
		CMD_BAD_START = 3'd4,
		CMD_BAD_TAIL  = 3'd5,
		CMD_TAIL_OK   = 3'd6
	} cmd_op_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [1:0]  status;
		logic [15:0] frame_length;
		logic        last;
	} out_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [7:0]  data;
		logic [15:0] len;
	} cmd_t;

	// reflected crc, one byte, lsb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int n = 0; n < 8; n++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/cfd_stream_if.sv @@
// valid/ready channel with a typed payload
// payload types come from cfd_pkg at the point of instantiation

interface cfd_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/cfd_front.sv @@
// front end: frame phase tracking, classifies each received byte and issues a command where one is due
// depends on cfd_pkg and cfd_stream_if

module cfd_front (
	input  logic         clk,
	input  logic         arst_n,
	cfd_stream_if.sink   rx,
	cfd_stream_if.source cmd
);

	typedef enum logic [8:0] {
		PH_HUNT1  = 9'b000000001,
		PH_HUNT2  = 9'b000000010,
		PH_LEN_HI = 9'b000000100,
		PH_LEN_LO = 9'b000001000,
		PH_DATA   = 9'b000010000,
		PH_CRC_HI = 9'b000100000,
		PH_CRC_LO = 9'b001000000,
		PH_TAIL1  = 9'b010000000,
		PH_TAIL2  = 9'b100000000
	} phase_t;

	phase_t        phase_q, phase_d;
	logic [15:0]   length_q, length_d;
	logic [15:0]   left_q, left_d;
	logic          has_cmd;
	cfd_pkg::cmd_t cmd_d;
	logic [7:0]    b;
	logic          take;

	assign b        = rx.data.rx_byte;
	assign rx.ready = cmd.ready;
	assign take     = rx.valid && rx.ready;

	always_comb begin
		phase_d   = phase_q;
		length_d  = length_q;
		left_d    = left_q;
		has_cmd   = 1'b0;
		cmd_d.op  = cfd_pkg::CMD_DATA;
		cmd_d.data = b;
		cmd_d.len  = length_q;
		unique case (phase_q)
			PH_HUNT2: begin
				if (b == cfd_pkg::START_BYTE2) begin
					phase_d = PH_LEN_HI;
				end else begin
					phase_d  = PH_HUNT1;
					has_cmd  = 1'b1;
					cmd_d.op = cfd_pkg::CMD_BAD_START;
				end
			end
			PH_LEN_HI: begin
				length_d = {b, 8'h00};
				phase_d  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_d = {length_q[15:8], b};
				left_d   = {length_q[15:8], b};
				has_cmd  = 1'b1;
				cmd_d.op = cfd_pkg::CMD_CRC_CLR;
				phase_d  = ({length_q[15:8], b} == 16'd0) ? PH_CRC_HI : PH_DATA;
			end
			PH_DATA: begin
				left_d   = left_q - 16'd1;
				has_cmd  = 1'b1;
				cmd_d.op = cfd_pkg::CMD_DATA;
				if (left_q == 16'd1) begin
					phase_d = PH_CRC_HI;
				end
			end
			PH_CRC_HI: begin
				has_cmd  = 1'b1;
				cmd_d.op = cfd_pkg::CMD_CRC_HI;
				phase_d  = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				has_cmd  = 1'b1;
				cmd_d.op = cfd_pkg::CMD_CRC_LO;
				phase_d  = PH_TAIL1;
			end
			PH_TAIL1: begin
				if (b == cfd_pkg::TAIL_BYTE1) begin
					phase_d = PH_TAIL2;
				end else begin
					phase_d  = PH_HUNT1;
					has_cmd  = 1'b1;
					cmd_d.op = cfd_pkg::CMD_BAD_TAIL;
				end
			end
			PH_TAIL2: begin
				phase_d  = PH_HUNT1;
				has_cmd  = 1'b1;
				cmd_d.op = (b == cfd_pkg::TAIL_BYTE2) ? cfd_pkg::CMD_TAIL_OK
				                                      : cfd_pkg::CMD_BAD_TAIL;
			end
			default: begin
				// hunting the first start byte
				phase_d = (b == cfd_pkg::START_BYTE1) ? PH_HUNT2 : PH_HUNT1;
			end
		endcase
	end

	assign cmd.valid = rx.valid && has_cmd;
	assign cmd.data  = cmd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT1;
			length_q <= 16'd0;
			left_q   <= 16'd0;
		end else if (take) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			left_q   <= left_d;
		end
	end

endmodule

@@ rtl/cfd_cmd_queue.sv @@
// short command queue between the front end and the back end
// depends on cfd_pkg and cfd_stream_if

module cfd_cmd_queue #(
	parameter int QDepth = cfd_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	cfd_stream_if.sink   wr,
	cfd_stream_if.source rd
);

	localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int CntW = $clog2(QDepth + 1);

	cfd_pkg::cmd_t  mem_q [QDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            push, pop;

	assign wr.ready = (cnt_q != CntW'(QDepth));
	assign rd.valid = (cnt_q != '0);
	assign rd.data  = mem_q[rd_ptr_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/cfd_back.sv @@
// back end: crc accumulation, crc compare and the registered result beat
// depends on cfd_pkg and cfd_stream_if

module cfd_back (
	input  logic         clk,
	input  logic         arst_n,
	cfd_stream_if.sink   cmd,
	cfd_stream_if.source tx
);

	logic [15:0]   crc_q, crc_d;
	logic [15:0]   rcrc_q, rcrc_d;
	cfd_pkg::out_t out_q, out_d;
	logic          out_valid_q;
	logic          emit;
	logic          pop;

	// take a command whenever the output slot is free or emptying this cycle
	assign cmd.ready = !out_valid_q || tx.ready;
	assign pop       = cmd.valid && cmd.ready;

	always_comb begin
		crc_d              = crc_q;
		rcrc_d             = rcrc_q;
		emit               = 1'b0;
		out_d.kind         = cfd_pkg::KIND_STATUS;
		out_d.data_byte    = 8'h00;
		out_d.status       = cfd_pkg::ST_OK;
		out_d.frame_length = cmd.data.len;
		out_d.last         = 1'b1;
		unique case (cmd.data.op)
			cfd_pkg::CMD_CRC_CLR: begin
				crc_d = cfd_pkg::CRC_INIT;
			end
			cfd_pkg::CMD_DATA: begin
				crc_d           = cfd_pkg::crc_byte(crc_q, cmd.data.data);
				emit            = 1'b1;
				out_d.kind      = cfd_pkg::KIND_DATA;
				out_d.data_byte = cmd.data.data;
				out_d.last      = 1'b0;
			end
			cfd_pkg::CMD_CRC_HI: begin
				rcrc_d = {cmd.data.data, 8'h00};
			end
			cfd_pkg::CMD_CRC_LO: begin
				rcrc_d = {rcrc_q[15:8], cmd.data.data};
			end
			cfd_pkg::CMD_BAD_START: begin
				emit               = 1'b1;
				out_d.status       = cfd_pkg::ST_START;
				out_d.frame_length = 16'd0;
			end
			cfd_pkg::CMD_BAD_TAIL: begin
				emit         = 1'b1;
				out_d.status = cfd_pkg::ST_TAIL;
			end
			cfd_pkg::CMD_TAIL_OK: begin
				emit         = 1'b1;
				out_d.status = (crc_q != rcrc_q) ? cfd_pkg::ST_CRC : cfd_pkg::ST_OK;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign tx.valid = out_valid_q;
	assign tx.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= cfd_pkg::CRC_INIT;
			rcrc_q      <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				crc_q  <= crc_d;
				rcrc_q <= rcrc_d;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_q <= out_d;
		end
	end

endmodule

@@ rtl/crc16_frame_deframer_core.sv @@
// top level of the length-prefixed frame deframer with crc-16/arc check
// depends on cfd_pkg, cfd_stream_if, cfd_front, cfd_cmd_queue, cfd_back
//
//  channel  dir  payload                                         beat when
//  rx       in   rx_byte                                         rx.valid && rx.ready
//  tx       out  kind, data_byte, status, frame_length, last     tx.valid && tx.ready
//
// one byte per cycle while tx does not stall: the front end classifies a byte in the
// cycle it is taken, the back end runs one byte-wide crc update per cycle.
// a byte's result is registered in the command queue and then in the output register.
// rx.ready drops only when the command queue is full, i.e. after a tx stall has filled
// it; reset is asynchronous and leaves the block hunting for a start.

module crc16_frame_deframer_core #(
	parameter int QDepth = cfd_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	cfd_stream_if.sink   rx,
	cfd_stream_if.source tx
);

	cfd_stream_if #(.T(cfd_pkg::cmd_t)) push_if ();
	cfd_stream_if #(.T(cfd_pkg::cmd_t)) pop_if ();

	cfd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.cmd    (push_if)
	);

	cfd_cmd_queue #(.QDepth(QDepth)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push_if),
		.rd     (pop_if)
	);

	cfd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (pop_if),
		.tx     (tx)
	);

endmodule
